[hdl/audio_dma_interface_core_defines.svh]
// Assertion macros shared by the audio DMA interface RTL.
`ifndef AUDIO_DMA_INTERFACE_CORE_DEFINES_SVH
`define AUDIO_DMA_INTERFACE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ADI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ADI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ADI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ADI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/adi_pkg.sv]
// Types and constants of the audio DMA interface.
package adi_pkg;

    // Access codes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register map.
    localparam logic [2:0] REG_ADDRESS  = 3'd0;
    localparam logic [2:0] REG_LENGTH   = 3'd1;
    localparam logic [2:0] REG_CONTROL  = 3'd2;
    localparam logic [2:0] REG_STATUS   = 3'd3;
    localparam logic [2:0] REG_DAC_RATE = 3'd4;
    localparam logic [2:0] REG_BIT_RATE = 3'd5;

    // Register masks.
    localparam logic [23:0] MASK_ADDR = 24'hFFFFF8;
    localparam logic [17:0] MASK_LEN  = 18'h3FFF8;
    localparam logic [13:0] MASK_DAC  = 14'h3FFF;
    localparam logic [3:0]  MASK_BIT  = 4'hF;

    // Buffer queue.
    localparam int         FIFO_DEPTH = 2;
    localparam logic [1:0] QUEUE_FULL = 2'(FIFO_DEPTH);

    // Clocks used to turn a buffer length into a playback time.
    localparam logic [25:0] DAC_CLOCK   = 26'd48681812;
    localparam logic [25:0] COUNT_CLOCK = 26'd62500000;

    // Shared divider geometry.
    localparam int DIV_W   = 42;
    localparam int DIVR_W  = 26;
    localparam int STEP_W  = 6;
    localparam int SAMP_W  = 16;
    localparam int CNT_W   = 31;

    // The DAC clock is placed at the top of the dividend so that 26 steps yield the rate.
    localparam logic [DIV_W-1:0]  FREQ_DIVIDEND = {DAC_CLOCK, 16'd0};
    localparam logic [STEP_W-1:0] FREQ_STEPS    = 6'd26;
    localparam logic [STEP_W-1:0] QUOT_STEPS    = 6'd42;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hdl/adi_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
`include "audio_dma_interface_core_defines.svh"

module adi_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  adi_pkg::t_div_ctl               i_ctl,
    input  logic [adi_pkg::DIV_W-1:0]       i_dividend,
    input  logic [adi_pkg::DIVR_W-1:0]      i_divisor,
    output adi_pkg::t_div_stat              o_stat,
    output logic [adi_pkg::DIV_W-1:0]       o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [adi_pkg::STEP_W-1:0]    r_cnt;
    logic [adi_pkg::DIVR_W-1:0]    r_rem;
    logic [adi_pkg::DIV_W-1:0]     r_quo;
    logic [adi_pkg::DIVR_W-1:0]    r_div;

    logic [adi_pkg::DIVR_W:0]      shifted;
    logic [adi_pkg::DIVR_W+1:0]    diff;

    assign shifted = {r_rem, r_quo[adi_pkg::DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == adi_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // A clear top bit means the trial subtraction did not borrow.
            if (!diff[adi_pkg::DIVR_W+1]) begin
                r_rem <= diff[adi_pkg::DIVR_W-1:0];
                r_quo <= {r_quo[adi_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[adi_pkg::DIVR_W-1:0];
                r_quo <= {r_quo[adi_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

    `ADI_ASSERT_IMPLY(a_no_restart, i_clk, i_rst_n, i_ctl.start, !r_busy,
        "divider restarted while busy")
    `ADI_ASSERT_IMPLY(a_cnt_live, i_clk, i_rst_n, r_busy, r_cnt != '0,
        "divider busy with no steps left")
    `ADI_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, r_done, !r_busy,
        "divider done while still busy")

endmodule

[hdl/audio_dma_interface_core.sv]
// Audio DMA interface: register file, two-buffer queue, playback countdown.
// An accepted beat is registered into the result registers, then into the output registers.
// o_stall holds off new beats until the result is loaded, which a stalled output can delay.
// A beat that starts a buffer of nonzero length runs the DAC rate pass (26 divider steps),
// then the count pass (42 steps); it loads the countdown and hands out the result beat.
// Synchronous active-low reset clears the register file, queue state, countdown and FSM.
`include "audio_dma_interface_core_defines.svh"

module audio_dma_interface_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic        o_irq_raise,
    output logic        o_irq_clear,
    output logic        o_buffer_start,
    output logic [23:0] o_buffer_address,
    output logic [17:0] o_buffer_length
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FREQ = 4'b0010,
        ST_QUOT = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state;

    // Architectural state.
    logic [23:0] r_address, n_address;
    logic [17:0] r_length, n_length;
    logic [31:0] r_control, n_control;
    logic        r_full, n_full;
    logic        r_busy, n_busy;
    logic [13:0] r_dac, n_dac;
    logic [3:0]  r_bit, n_bit;
    logic [23:0] r_slot_address [adi_pkg::FIFO_DEPTH];
    logic [23:0] n_slot_address [adi_pkg::FIFO_DEPTH];
    logic [17:0] r_slot_length [adi_pkg::FIFO_DEPTH];
    logic [17:0] n_slot_length [adi_pkg::FIFO_DEPTH];
    logic        r_write_slot, n_write_slot;
    logic        r_read_slot, n_read_slot;
    logic [1:0]  r_queued_count, n_queued_count;
    logic [adi_pkg::CNT_W-1:0] r_countdown, n_countdown;

    // Result of the step being processed.
    logic [31:0] n_read_data;
    logic        n_irq_raise, n_irq_clear, n_buffer_start, n_need_div;
    logic [23:0] n_buffer_address;
    logic [17:0] n_buffer_length;
    logic        head_start;

    logic [31:0] r_res_read_data;
    logic        r_res_irq_raise, r_res_irq_clear, r_res_buffer_start;
    logic [23:0] r_res_buffer_address;
    logic [17:0] r_res_buffer_length;
    logic [adi_pkg::SAMP_W-1:0] r_samples;

    logic        r_out_valid;
    logic [31:0] r_out_read_data;
    logic        r_out_irq_raise, r_out_irq_clear, r_out_buffer_start;
    logic [23:0] r_out_buffer_address;
    logic [17:0] r_out_buffer_length;

    logic                        in_acc;
    logic                        out_load;
    logic [31:0]                 status_word;
    adi_pkg::t_div_ctl           div_ctl;
    adi_pkg::t_div_stat          div_stat;
    logic [adi_pkg::DIV_W-1:0]   div_dividend;
    logic [adi_pkg::DIVR_W-1:0]  div_divisor;
    logic [adi_pkg::DIV_W-1:0]   div_quotient;
    logic [adi_pkg::DIV_W-1:0]   count_product;
    logic [14:0]                 dac_divisor;

    assign in_acc   = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    // Status holds only the full pair (bits 31 and 0) and the busy bit (bit 30).
    assign status_word = {r_full, r_busy, 29'd0, r_full};

    always_comb begin
        n_address      = r_address;
        n_length       = r_length;
        n_control      = r_control;
        n_full         = r_full;
        n_busy         = r_busy;
        n_dac          = r_dac;
        n_bit          = r_bit;
        n_slot_address = r_slot_address;
        n_slot_length  = r_slot_length;
        n_write_slot   = r_write_slot;
        n_read_slot    = r_read_slot;
        n_queued_count = r_queued_count;
        n_countdown    = r_countdown;
        n_read_data      = '0;
        n_irq_raise      = 1'b0;
        n_irq_clear      = 1'b0;
        n_buffer_start   = 1'b0;
        n_buffer_address = '0;
        n_buffer_length  = '0;
        n_need_div       = 1'b0;
        head_start       = 1'b0;

        case (i_opcode)
            adi_pkg::OP_TICK: begin
                if (r_countdown != '0) begin
                    n_countdown = r_countdown - adi_pkg::CNT_W'(1);
                    // Expiry retires the head buffer and starts the next one if queued.
                    if ((n_countdown == '0) && (r_queued_count != '0)) begin
                        n_irq_raise    = 1'b1;
                        n_read_slot    = ~r_read_slot;
                        n_full         = 1'b0;
                        n_busy         = 1'b0;
                        n_queued_count = r_queued_count - 2'd1;
                        if (n_queued_count != '0) begin
                            n_busy     = 1'b1;
                            head_start = 1'b1;
                        end
                    end
                end
            end
            adi_pkg::OP_READ: begin
                case (i_reg_index)
                    adi_pkg::REG_ADDRESS:  n_read_data = {8'd0, r_address};
                    adi_pkg::REG_LENGTH:   n_read_data = r_full ? {14'd0, r_length} : 32'd0;
                    adi_pkg::REG_CONTROL:  n_read_data = r_control;
                    adi_pkg::REG_STATUS:   n_read_data = status_word;
                    adi_pkg::REG_DAC_RATE: n_read_data = {18'd0, r_dac};
                    adi_pkg::REG_BIT_RATE: n_read_data = {28'd0, r_bit};
                    default:               n_read_data = '0;
                endcase
            end
            adi_pkg::OP_WRITE: begin
                case (i_reg_index)
                    adi_pkg::REG_ADDRESS:  n_address = i_write_data[23:0] & adi_pkg::MASK_ADDR;
                    adi_pkg::REG_LENGTH: begin
                        n_length = i_write_data[17:0] & adi_pkg::MASK_LEN;
                        if (r_queued_count != adi_pkg::QUEUE_FULL) begin
                            n_slot_address[r_write_slot] = r_address;
                            n_slot_length[r_write_slot]  = n_length;
                            n_write_slot   = ~r_write_slot;
                            n_queued_count = r_queued_count + 2'd1;
                            if (n_queued_count == adi_pkg::QUEUE_FULL) begin
                                n_full = 1'b1;
                            end
                            if (!r_busy) begin
                                n_full     = 1'b0;
                                n_busy     = 1'b1;
                                head_start = 1'b1;
                            end
                        end
                    end
                    adi_pkg::REG_CONTROL:  n_control = i_write_data;
                    adi_pkg::REG_STATUS:   n_irq_clear = 1'b1;
                    adi_pkg::REG_DAC_RATE: n_dac = i_write_data[13:0] & adi_pkg::MASK_DAC;
                    adi_pkg::REG_BIT_RATE: n_bit = i_write_data[3:0] & adi_pkg::MASK_BIT;
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (head_start) begin
            if (n_slot_length[n_read_slot] != '0) begin
                n_need_div       = 1'b1;
                n_buffer_start   = 1'b1;
                n_buffer_address = n_slot_address[n_read_slot];
                n_buffer_length  = n_slot_length[n_read_slot];
            end else begin
                // An empty buffer retires at once; a queued follower retires on the next tick.
                n_irq_raise = 1'b1;
                n_read_slot = ~n_read_slot;
                n_full      = 1'b0;
                n_busy      = 1'b0;
                if (n_queued_count != '0) begin
                    n_queued_count = n_queued_count - 2'd1;
                end
                if (n_queued_count != '0) begin
                    n_busy      = 1'b1;
                    n_countdown = adi_pkg::CNT_W'(1);
                end
            end
        end
    end

    // First pass: DAC clock over (rate + 1). Second pass: count clock times samples over that.
    assign dac_divisor   = {1'b0, r_dac} + 15'd1;
    assign count_product = adi_pkg::COUNT_CLOCK * r_samples;

    always_comb begin
        if (r_state == ST_FREQ) begin
            div_ctl.start = div_stat.done;
            div_ctl.steps = adi_pkg::QUOT_STEPS;
            div_dividend  = count_product;
            div_divisor   = div_quotient[adi_pkg::DIVR_W-1:0];
        end else begin
            div_ctl.start = in_acc && n_need_div;
            div_ctl.steps = adi_pkg::FREQ_STEPS;
            div_dividend  = adi_pkg::FREQ_DIVIDEND;
            div_divisor   = {11'd0, dac_divisor};
        end
    end

    adi_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_address      <= '0;
            r_length       <= '0;
            r_control      <= '0;
            r_full         <= 1'b0;
            r_busy         <= 1'b0;
            r_dac          <= '0;
            r_bit          <= '0;
            r_write_slot   <= 1'b0;
            r_read_slot    <= 1'b0;
            r_queued_count <= '0;
            r_countdown    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_address      <= n_address;
                        r_length       <= n_length;
                        r_control      <= n_control;
                        r_full         <= n_full;
                        r_busy         <= n_busy;
                        r_dac          <= n_dac;
                        r_bit          <= n_bit;
                        r_write_slot   <= n_write_slot;
                        r_read_slot    <= n_read_slot;
                        r_queued_count <= n_queued_count;
                        r_countdown    <= n_countdown;
                        r_state        <= n_need_div ? ST_FREQ : ST_DONE;
                    end
                end
                ST_FREQ: begin
                    if (div_stat.done) begin
                        r_state <= ST_QUOT;
                    end
                end
                ST_QUOT: begin
                    if (div_stat.done) begin
                        r_countdown <= div_quotient[adi_pkg::CNT_W-1:0];
                        r_state     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot_address       <= n_slot_address;
            r_slot_length        <= n_slot_length;
            r_res_read_data      <= n_read_data;
            r_res_irq_raise      <= n_irq_raise;
            r_res_irq_clear      <= n_irq_clear;
            r_res_buffer_start   <= n_buffer_start;
            r_res_buffer_address <= n_buffer_address;
            r_res_buffer_length  <= n_buffer_length;
            r_samples            <= n_buffer_length[17:2];
        end
        if (out_load) begin
            r_out_read_data      <= r_res_read_data;
            r_out_irq_raise      <= r_res_irq_raise;
            r_out_irq_clear      <= r_res_irq_clear;
            r_out_buffer_start   <= r_res_buffer_start;
            r_out_buffer_address <= r_res_buffer_address;
            r_out_buffer_length  <= r_res_buffer_length;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_data      = r_out_read_data;
    assign o_irq_raise      = r_out_irq_raise;
    assign o_irq_clear      = r_out_irq_clear;
    assign o_buffer_start   = r_out_buffer_start;
    assign o_buffer_address = r_out_buffer_address;
    assign o_buffer_length  = r_out_buffer_length;

    `ADI_ASSERT_IMPLY(a_div_in_seq, i_clk, i_rst_n, div_stat.busy,
        (r_state == ST_FREQ) || (r_state == ST_QUOT), "divider running outside a divide state")
    `ADI_ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, r_full,
        r_queued_count == adi_pkg::QUEUE_FULL, "full flag without a full queue")
    `ADI_ASSERT_IMPLY(a_count_busy, i_clk, i_rst_n, r_countdown != '0, r_busy,
        "countdown running while not busy")
    `ADI_ASSERT_NEXT(a_count_load, i_clk, i_rst_n, (r_state == ST_QUOT) && div_stat.done,
        r_countdown != '0, "started buffer loaded an empty countdown")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the audio DMA interface core: directed and random bus accesses.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0]  OP_NONE       = 2'd3;
    localparam logic [2:0]  REG_UNUSED_LO = 3'd6;
    localparam logic [2:0]  REG_UNUSED_HI = 3'd7;
    localparam logic [31:0] ST_FULL       = 32'h80000001;
    localparam logic [31:0] ST_BUSY       = 32'h40000000;
    localparam logic [31:0] ST_FULL_BUSY  = ST_FULL | ST_BUSY;
    localparam int          ITEM_TARGET   = 650;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_CYCLES  = 150;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  idx;
        logic [31:0] data;
    } t_access;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_raise;
        logic        irq_clear;
        logic        buffer_start;
        logic [23:0] buffer_address;
        logic [17:0] buffer_length;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = adi_pkg::OP_TICK;
    logic [2:0]  i_reg_index = adi_pkg::REG_ADDRESS;
    logic [31:0] i_write_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_read_data;
    logic        o_irq_raise;
    logic        o_irq_clear;
    logic        o_buffer_start;
    logic [23:0] o_buffer_address;
    logic [17:0] o_buffer_length;

    audio_dma_interface_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_reg_index     (i_reg_index),
        .i_write_data    (i_write_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_data     (o_read_data),
        .o_irq_raise     (o_irq_raise),
        .o_irq_clear     (o_irq_clear),
        .o_buffer_start  (o_buffer_start),
        .o_buffer_address(o_buffer_address),
        .o_buffer_length (o_buffer_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the register file, the buffer queue and the playback countdown.
    logic [23:0] m_address;
    logic [17:0] m_length;
    logic [31:0] m_control;
    logic [31:0] m_status;
    logic [13:0] m_dac;
    logic [3:0]  m_bits;
    logic [23:0] slot_addr [2];
    logic [17:0] slot_len [2];
    logic        wr_slot;
    logic        rd_slot;
    logic [1:0]  queued;
    logic [30:0] countdown;
    t_outcome    ev;

    t_access  pending_accesses [$];
    t_outcome pending_outcomes [$];
    int       item_total = 0;

    function automatic void retire_head();
        ev.irq_raise = 1'b1;
        rd_slot = ~rd_slot;
        m_status &= ~ST_FULL_BUSY;
        if (queued != 0)
            queued--;
    endfunction

    function automatic void start_head();
        longint unsigned rate;
        longint unsigned span;
        if (slot_len[rd_slot] != 0) begin
            rate = adi_pkg::DAC_CLOCK;
            rate = rate / (m_dac + 64'd1);
            span = adi_pkg::COUNT_CLOCK;
            span = span * (slot_len[rd_slot] >> 2) / rate;
            countdown = span[30:0];
            ev.buffer_start = 1'b1;
            ev.buffer_address = slot_addr[rd_slot];
            ev.buffer_length = slot_len[rd_slot];
        end else begin
            // An empty buffer is never played; it retires on the spot.
            retire_head();
            if (queued != 0) begin
                m_status |= ST_BUSY;
                countdown = 31'd1;
            end
        end
    endfunction

    function automatic t_outcome access_outcome(t_access a);
        ev = '0;
        case (a.op)
            adi_pkg::OP_TICK: begin
                if (countdown != 0) begin
                    countdown--;
                    if (countdown == 0 && queued != 0) begin
                        retire_head();
                        if (queued != 0) begin
                            m_status = ST_BUSY;
                            start_head();
                        end
                    end
                end
            end
            adi_pkg::OP_READ: begin
                case (a.idx)
                    adi_pkg::REG_ADDRESS:  ev.read_data = 32'(m_address);
                    adi_pkg::REG_LENGTH:
                        ev.read_data = ((m_status & ST_FULL) != 0) ? 32'(m_length) : '0;
                    adi_pkg::REG_CONTROL:  ev.read_data = m_control;
                    adi_pkg::REG_STATUS:   ev.read_data = m_status;
                    adi_pkg::REG_DAC_RATE: ev.read_data = 32'(m_dac);
                    adi_pkg::REG_BIT_RATE: ev.read_data = 32'(m_bits);
                    default:               ev.read_data = '0;
                endcase
            end
            adi_pkg::OP_WRITE: begin
                case (a.idx)
                    adi_pkg::REG_ADDRESS: m_address = a.data[23:0] & adi_pkg::MASK_ADDR;
                    adi_pkg::REG_LENGTH: begin
                        m_length = a.data[17:0] & adi_pkg::MASK_LEN;
                        if (queued < adi_pkg::QUEUE_FULL) begin
                            slot_addr[wr_slot] = m_address;
                            slot_len[wr_slot] = m_length;
                            wr_slot = ~wr_slot;
                            queued++;
                            if (queued == adi_pkg::QUEUE_FULL)
                                m_status |= ST_FULL;
                            if ((m_status & ST_BUSY) == '0) begin
                                m_status = ST_BUSY;
                                start_head();
                            end
                        end
                    end
                    adi_pkg::REG_CONTROL:  m_control = a.data;
                    adi_pkg::REG_STATUS:   ev.irq_clear = 1'b1;
                    adi_pkg::REG_DAC_RATE: m_dac = a.data[13:0] & adi_pkg::MASK_DAC;
                    adi_pkg::REG_BIT_RATE: m_bits = a.data[3:0] & adi_pkg::MASK_BIT;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return ev;
    endfunction

    function automatic void queue_access(logic [1:0] op, logic [2:0] idx, logic [31:0] data);
        t_access a;
        a = '{op: op, idx: idx, data: data};
        item_total++;
        pending_outcomes.push_back(access_outcome(a));
        pending_accesses.push_back(a);
    endfunction

    // Handshake bookkeeping, idling and pressure.
    logic        in_beat = 1'b0;
    int          accepted_count = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    logic        hold_off = 1'b0;
    logic        quiet;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          checked = 0;
    int          starts_seen = 0;
    int          irqs_seen = 0;
    int          clears_seen = 0;

    assign quiet = (pending_accesses.size() < 120)
                   || (accepted_count >= 300 && accepted_count < 380);

    always @(negedge i_clk) begin
        t_access nxt;
        if (i_rst_n && (!i_valid || in_beat)) begin
            if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
                nxt = pending_accesses.pop_front();
                i_valid <= 1'b1;
                i_opcode <= nxt.op;
                i_reg_index <= nxt.idx;
                i_write_data <= nxt.data;
                if (!quiet && $urandom_range(0, 7) == 0)
                    tx_gap <= $urandom_range(1, 15);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_gap != 0)
            rx_gap <= rx_gap - 1;
        else if (i_rst_n && !quiet && $urandom_range(0, 7) == 0)
            rx_gap <= $urandom_range(1, 15);
        i_stall <= hold_off || (rx_gap != 0);
    end

    // One long hold-off on the result side so the block backs up and stalls its input.
    initial begin
        wait (accepted_count >= 150);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        in_beat <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            accepted_count <= accepted_count + 1;
    end

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_read_data, o_irq_raise, o_irq_clear, o_buffer_start,
                    o_buffer_address, o_buffer_length};
            if (pending_outcomes.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result beat: rd=%h irq=%b clr=%b %s",
                             $realtime, got.read_data, got.irq_raise, got.irq_clear,
                             $sformatf("start=%b addr=%h len=%h", got.buffer_start,
                                       got.buffer_address, got.buffer_length));
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                checked++;
                starts_seen += want.buffer_start;
                irqs_seen += want.irq_raise;
                clears_seen += want.irq_clear;
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("[%0t] mismatch on result %0d:", $realtime, checked);
                        $display("    expected rd=%h irq=%b clr=%b start=%b addr=%h len=%h",
                                 want.read_data, want.irq_raise, want.irq_clear,
                                 want.buffer_start, want.buffer_address,
                                 want.buffer_length);
                        $display("    got      rd=%h irq=%b clr=%b start=%b addr=%h len=%h",
                                 got.read_data, got.irq_raise, got.irq_clear,
                                 got.buffer_start, got.buffer_address, got.buffer_length);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_outcomes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int          pick;
        int          n;
        int          guard;
        logic [31:0] lenw;

        m_address = '0;
        m_length = '0;
        m_control = '0;
        m_status = '0;
        m_dac = '0;
        m_bits = '0;
        wr_slot = 1'b0;
        rd_slot = 1'b0;
        queued = '0;
        countdown = '0;

        // Directed: register extremes, unmapped accesses, then the queue corner cases.
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_STATUS, '0);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_LENGTH, '0);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_CONTROL, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_CONTROL, '0);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_CONTROL, 32'h0);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_BIT_RATE, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_BIT_RATE, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_DAC_RATE, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_DAC_RATE, '0);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_DAC_RATE, 32'h0);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_ADDRESS, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_ADDRESS, '0);
        queue_access(adi_pkg::OP_WRITE, REG_UNUSED_LO, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_READ, REG_UNUSED_HI, '0);
        queue_access(OP_NONE, REG_UNUSED_HI, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_TICK, adi_pkg::REG_ADDRESS, '0);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_LENGTH, 32'h7);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_STATUS, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_LENGTH, 32'h8);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_LENGTH, 32'h0);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_LENGTH, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_LENGTH, '0);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_STATUS, '0);
        queue_access(adi_pkg::OP_TICK, adi_pkg::REG_STATUS, '0);
        queue_access(adi_pkg::OP_TICK, adi_pkg::REG_STATUS, '0);

        // Random: mostly queued buffers played out by ticks, with reads and writes mixed in.
        // Rates and lengths stay small so buffers retire within a few dozen ticks.
        while (item_total < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                if (m_dac == 0 && $urandom_range(0, 9) == 0)
                    lenw = 32'($urandom_range(0, 31)) << 3;
                else
                    lenw = 32'($urandom_range(0, 4)) << 3;
                queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_ADDRESS, $urandom);
                queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_LENGTH,
                             ($urandom & ~32'h3FFF8) | lenw);
            end else if (pick < 60) begin
                n = $urandom_range(1, ((countdown > 60) ? 60 : int'(countdown)) + 4);
                repeat (n) queue_access(adi_pkg::OP_TICK, 3'($urandom), $urandom);
            end else if (pick < 72) begin
                queue_access(adi_pkg::OP_READ, 3'($urandom_range(0, 7)), $urandom);
            end else if (pick < 78) begin
                queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_STATUS, $urandom);
            end else if (pick < 83) begin
                queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_CONTROL, $urandom);
            end else if (pick < 86) begin
                queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_BIT_RATE, $urandom);
            end else if (pick < 90) begin
                queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_DAC_RATE,
                             ($urandom & 32'hFFFFC000) | 32'($urandom_range(0, 3)));
            end else if (pick < 93) begin
                // A slow rate is only set briefly while nothing can start.
                if (queued == 0) begin
                    queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_DAC_RATE, $urandom);
                    queue_access(adi_pkg::OP_READ, adi_pkg::REG_DAC_RATE, $urandom);
                    queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_DAC_RATE,
                                 $urandom & 32'hFFFFC000);
                end
            end else if (pick < 96) begin
                if (queued == adi_pkg::QUEUE_FULL) begin
                    queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_LENGTH, $urandom);
                    queue_access(adi_pkg::OP_READ, adi_pkg::REG_LENGTH, $urandom);
                end
            end else if ($urandom_range(0, 1) == 0) begin
                queue_access(OP_NONE, 3'($urandom), $urandom);
            end else begin
                queue_access(adi_pkg::OP_WRITE,
                             3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
            end
        end

        // Play out whatever is queued, then start the longest buffer at the slowest rate.
        guard = 0;
        while (queued != 0 && guard < 4000) begin
            queue_access(adi_pkg::OP_TICK, 3'($urandom), $urandom);
            guard++;
        end
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_DAC_RATE, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_ADDRESS, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_LENGTH, 32'hFFFFFFFF);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_STATUS, '0);
        queue_access(adi_pkg::OP_TICK, adi_pkg::REG_ADDRESS, '0);
        queue_access(adi_pkg::OP_WRITE, adi_pkg::REG_LENGTH, 32'h8);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_LENGTH, '0);
        queue_access(adi_pkg::OP_READ, adi_pkg::REG_STATUS, '0);
        queue_access(adi_pkg::OP_TICK, adi_pkg::REG_ADDRESS, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_accesses.size() != 0 || i_valid || pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d result beats over %0d accepted accesses, %0d mismatches.",
                 checked, accepted_count, mismatches);
        $display("Seen %0d buffer starts, %0d interrupts raised, %0d interrupt clears.",
                 starts_seen, irqs_seen, clears_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
